### sv/beacon_identify_ack_handshake_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the beacon / identify / acknowledge handshake core
// Same-cycle and next-cycle implication checks. They compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BEACON_IDENTIFY_ACK_HANDSHAKE_CORE_MACROS_SVH
`define BEACON_IDENTIFY_ACK_HANDSHAKE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BIAH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIAH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define BIAH_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BIAH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/biah_pkg.sv
// ----------------------------------------------------------------------------
// biah_pkg
// Types, register indexes and reset values of the handshake core.
// ----------------------------------------------------------------------------
`default_nettype none

package biah_pkg;

    typedef enum logic [1:0] {
        PH_LISTEN    = 2'd0,
        PH_AWAIT_ID  = 2'd1,
        PH_AWAIT_ACK = 2'd2,
        PH_CONNECTED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CFG_OWN_ID        = 3'd0,
        CFG_MIN_ID        = 3'd1,
        CFG_MAX_ID        = 3'd2,
        CFG_BEACON_CODE   = 3'd3,
        CFG_IAM_CODE      = 3'd4,
        CFG_ACK_CODE      = 3'd5,
        CFG_BEACON_PERIOD = 3'd6,
        CFG_REPLY_TIMEOUT = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CNT_W      = 16;

    localparam logic [3:0]       RST_OWN_ID        = 4'd1;
    localparam logic [3:0]       RST_MIN_ID        = 4'd0;
    localparam logic [3:0]       RST_MAX_ID        = 4'd15;
    localparam logic [7:0]       RST_BEACON_CODE   = 8'd0;
    localparam logic [7:0]       RST_IAM_CODE      = 8'd1;
    localparam logic [7:0]       RST_ACK_CODE      = 8'd2;
    localparam logic [CNT_W-1:0] RST_BEACON_PERIOD = 16'd1000;
    localparam logic [CNT_W-1:0] RST_REPLY_TIMEOUT = 16'd5000;

    // Message code plus an identifier shifted into the upper nibble, modulo 256.
    function automatic logic [7:0] code_with_id(input logic [7:0] code, input logic [3:0] id);
        return code + {id, 4'b0000};
    endfunction

    // Increment that sticks at all ones.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

### sv/beacon_identify_ack_handshake_core.sv
// ----------------------------------------------------------------------------
// beacon_identify_ack_handshake_core
// A result is registered at the edge that accepts its request.
// Throughput: one request per cycle while the result side takes results; the output register frees as it is taken.
// Reset (synchronous, active low): listen phase, counters and visitor cleared,
// configuration registers back to their defaults, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "beacon_identify_ack_handshake_core_macros.svh"

module beacon_identify_ack_handshake_core import biah_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_rx_byte,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_tx_valid,
    output logic [7:0]                 o_tx_byte,
    output logic [1:0]                 o_phase,
    output logic                       o_connected,
    output logic [7:0]                 o_visitor_id
);

    // Configuration registers
    logic [3:0]       r_own_id;
    logic [3:0]       r_min_id;
    logic [3:0]       r_max_id;
    logic [7:0]       r_beacon_code;
    logic [7:0]       r_iam_code;
    logic [7:0]       r_ack_code;
    logic [CNT_W-1:0] r_beacon_period;
    logic [CNT_W-1:0] r_reply_timeout;

    // Handshake state
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_beacon_elapsed, n_beacon_elapsed;
    logic [CNT_W-1:0] r_wait_elapsed, n_wait_elapsed;
    logic [7:0]       r_visitor, n_visitor;

    // Output register
    logic             r_out_valid;
    logic             r_out_tx_valid;
    logic [7:0]       r_out_tx_byte;
    logic [1:0]       r_out_phase;
    logic             r_out_connected;
    logic [7:0]       r_out_visitor;

    logic             w_in_fire;
    logic             w_tick;
    logic             w_await;
    logic [CNT_W-1:0] w_be_inc;
    logic [CNT_W-1:0] w_wait_inc;
    logic             w_tick_tmo;
    logic             w_beacon;
    logic             w_byte_late;
    logic             w_iam_hit;
    logic             w_id_ok;
    logic             w_ack_hit;
    logic             w_id_accept;
    logic             n_tx_valid;
    logic [7:0]       n_tx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id        <= RST_OWN_ID;
            r_min_id        <= RST_MIN_ID;
            r_max_id        <= RST_MAX_ID;
            r_beacon_code   <= RST_BEACON_CODE;
            r_iam_code      <= RST_IAM_CODE;
            r_ack_code      <= RST_ACK_CODE;
            r_beacon_period <= RST_BEACON_PERIOD;
            r_reply_timeout <= RST_REPLY_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OWN_ID:        r_own_id        <= i_cfg_data[3:0];
                CFG_MIN_ID:        r_min_id        <= i_cfg_data[3:0];
                CFG_MAX_ID:        r_max_id        <= i_cfg_data[3:0];
                CFG_BEACON_CODE:   r_beacon_code   <= i_cfg_data[7:0];
                CFG_IAM_CODE:      r_iam_code      <= i_cfg_data[7:0];
                CFG_ACK_CODE:      r_ack_code      <= i_cfg_data[7:0];
                CFG_BEACON_PERIOD: r_beacon_period <= i_cfg_data[CNT_W-1:0];
                CFG_REPLY_TIMEOUT: r_reply_timeout <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_tick     = !i_req_type;
    assign w_await    = (r_phase == PH_AWAIT_ID) || (r_phase == PH_AWAIT_ACK);
    assign w_be_inc   = sat_inc(r_beacon_elapsed);
    assign w_wait_inc = sat_inc(r_wait_elapsed);

    // A tick that times out an await phase lands in listen and may beacon at once.
    assign w_tick_tmo  = w_await && (w_wait_inc >= r_reply_timeout);
    assign w_beacon    = w_tick && ((r_phase == PH_LISTEN) || w_tick_tmo)
                         && (w_be_inc >= r_beacon_period);
    assign w_byte_late = r_wait_elapsed >= r_reply_timeout;
    assign w_iam_hit   = i_rx_byte == code_with_id(r_iam_code, r_own_id);
    assign w_ack_hit   = i_rx_byte == code_with_id(r_ack_code, r_own_id);
    assign w_id_ok     = (i_rx_byte >= {4'b0000, r_min_id}) && (i_rx_byte <= {4'b0000, r_max_id});
    assign w_id_accept = !w_tick && (r_phase == PH_AWAIT_ID) && !w_byte_late && w_id_ok;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_LISTEN: begin
                if (!w_tick && w_iam_hit) n_phase = PH_AWAIT_ID;
            end
            PH_AWAIT_ID: begin
                if (w_tick) begin
                    if (w_tick_tmo) n_phase = PH_LISTEN;
                end else if (w_byte_late || !w_id_ok) begin
                    n_phase = PH_LISTEN;
                end else begin
                    n_phase = PH_AWAIT_ACK;
                end
            end
            PH_AWAIT_ACK: begin
                if (w_tick) begin
                    if (w_tick_tmo) n_phase = PH_LISTEN;
                end else if (w_byte_late) begin
                    n_phase = PH_LISTEN;
                end else if (w_ack_hit) begin
                    n_phase = PH_CONNECTED;
                end
            end
            PH_CONNECTED: n_phase = PH_CONNECTED;
            default:      n_phase = PH_LISTEN;
        endcase
    end

    // Counters, visitor and transmit byte
    always_comb begin
        n_beacon_elapsed = r_beacon_elapsed;
        n_wait_elapsed   = r_wait_elapsed;
        n_visitor        = r_visitor;
        n_tx_valid       = 1'b0;
        n_tx_byte        = 8'd0;
        if (r_phase != PH_CONNECTED) begin
            if (w_tick) begin
                n_beacon_elapsed = w_beacon ? '0 : w_be_inc;
                if (w_await) n_wait_elapsed = w_wait_inc;
            end else if (r_phase == PH_LISTEN) begin
                if (w_iam_hit) n_wait_elapsed = '0;
            end else if (!w_byte_late && (r_phase == PH_AWAIT_ID)) begin
                n_visitor = i_rx_byte;
                if (w_id_ok) n_wait_elapsed = '0;
            end
        end
        if (w_beacon) begin
            n_tx_valid = 1'b1;
            n_tx_byte  = code_with_id(r_beacon_code, r_own_id);
        end else if (w_id_accept) begin
            n_tx_valid = 1'b1;
            n_tx_byte  = code_with_id(r_ack_code, i_rx_byte[3:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_LISTEN;
            r_beacon_elapsed <= '0;
            r_wait_elapsed   <= '0;
            r_visitor        <= 8'd0;
        end else if (w_in_fire) begin
            r_phase          <= n_phase;
            r_beacon_elapsed <= n_beacon_elapsed;
            r_wait_elapsed   <= n_wait_elapsed;
            r_visitor        <= n_visitor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_tx_valid  <= n_tx_valid;
            r_out_tx_byte   <= n_tx_byte;
            r_out_phase     <= n_phase;
            r_out_connected <= (n_phase == PH_CONNECTED);
            r_out_visitor   <= n_visitor;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tx_valid   = r_out_tx_valid;
    assign o_tx_byte    = r_out_tx_byte;
    assign o_phase      = r_out_phase;
    assign o_connected  = r_out_connected;
    assign o_visitor_id = r_out_visitor;

    // Once connected the block never leaves that phase short of reset.
    `BIAH_ASSERT_NEXT(a_connected_sticky, i_clk, i_rst_n, r_phase == PH_CONNECTED, r_phase == PH_CONNECTED)
    // A sent byte is either a beacon (listen) or an acknowledge (await ack).
    `BIAH_ASSERT_SAME(a_tx_phase, i_clk, i_rst_n, r_out_valid && r_out_tx_valid, (r_out_phase == PH_LISTEN) || (r_out_phase == PH_AWAIT_ACK))
    // Nothing to send reads as a zero byte.
    `BIAH_ASSERT_SAME(a_tx_idle_zero, i_clk, i_rst_n, r_out_valid && !r_out_tx_valid, r_out_tx_byte == 8'd0)
    // Sending a beacon restarts the beacon count.
    `BIAH_ASSERT_NEXT(a_beacon_clears, i_clk, i_rst_n, w_in_fire && w_beacon, r_beacon_elapsed == '0)

endmodule

`default_nettype wire

### verif/beacon_identify_ack_handshake_checker.sv
// ----------------------------------------------------------------------------
// Handshake core result checker
// Follows the register writes and the request channel, predicts the result of
// every accepted request and compares it field by field with what the core
// returns. The count of mismatches and of results still due go to the top.
// ----------------------------------------------------------------------------
module beacon_identify_ack_handshake_checker import biah_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_req_type,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_tx_valid,
    input  logic [7:0]            i_tx_byte,
    input  logic [1:0]            i_phase,
    input  logic                  i_connected,
    input  logic [7:0]            i_visitor_id,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 40;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        t_phase     phase;
        logic       connected;
        logic [7:0] visitor;
    } t_link_result;

    logic [3:0]   own_id;
    logic [3:0]   min_id;
    logic [3:0]   max_id;
    logic [7:0]   beacon_code;
    logic [7:0]   iam_code;
    logic [7:0]   ack_code;
    logic [15:0]  beacon_period;
    logic [15:0]  reply_timeout;

    t_phase       link_phase;
    logic [15:0]  beacon_ticks;
    logic [15:0]  reply_ticks;
    logic [7:0]   visitor_seen;

    t_link_result results_due[$];
    int           mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic logic [15:0] bump_sat(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] with_id(input logic [7:0] code, input logic [7:0] id);
        return 8'(code + 16 * id[3:0]);
    endfunction

    // Applies one request to the predicted link state and returns its result.
    function automatic t_link_result advance_link(input logic is_byte, input logic [7:0] rx);
        t_link_result r;
        r = '0;
        if (link_phase != PH_CONNECTED) begin
            if (!is_byte) begin
                beacon_ticks = bump_sat(beacon_ticks);
                if (link_phase == PH_AWAIT_ID || link_phase == PH_AWAIT_ACK) begin
                    reply_ticks = bump_sat(reply_ticks);
                    if (reply_ticks >= reply_timeout) begin
                        link_phase = PH_LISTEN;
                    end
                end
                // The tick that times out a reply may send the beacon at once.
                if (link_phase == PH_LISTEN && beacon_ticks >= beacon_period) begin
                    r.tx_valid   = 1'b1;
                    r.tx_byte    = with_id(beacon_code, 8'(own_id));
                    beacon_ticks = '0;
                end
            end else if (link_phase == PH_LISTEN) begin
                if (rx == with_id(iam_code, 8'(own_id))) begin
                    link_phase  = PH_AWAIT_ID;
                    reply_ticks = '0;
                end
            end else if (reply_ticks >= reply_timeout) begin
                // A byte that comes too late is dropped.
                link_phase = PH_LISTEN;
            end else if (link_phase == PH_AWAIT_ID) begin
                visitor_seen = rx;
                if (rx >= min_id && rx <= max_id) begin
                    r.tx_valid  = 1'b1;
                    r.tx_byte   = with_id(ack_code, rx);
                    link_phase  = PH_AWAIT_ACK;
                    reply_ticks = '0;
                end else begin
                    link_phase = PH_LISTEN;
                end
            end else if (rx == with_id(ack_code, 8'(own_id))) begin
                link_phase = PH_CONNECTED;
            end
        end
        r.phase     = link_phase;
        r.connected = (link_phase == PH_CONNECTED);
        r.visitor   = visitor_seen;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_link_result due;
        if (!i_rst_n) begin
            own_id        = RST_OWN_ID;
            min_id        = RST_MIN_ID;
            max_id        = RST_MAX_ID;
            beacon_code   = RST_BEACON_CODE;
            iam_code      = RST_IAM_CODE;
            ack_code      = RST_ACK_CODE;
            beacon_period = RST_BEACON_PERIOD;
            reply_timeout = RST_REPLY_TIMEOUT;
            link_phase    = PH_LISTEN;
            beacon_ticks  = '0;
            reply_ticks   = '0;
            visitor_seen  = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: result with no request waiting, expected none, actual %0h",
                                 $time, i_tx_byte);
                    end
                end else begin
                    due = results_due.pop_front();
                    check_field("tx_valid", 8'(due.tx_valid), 8'(i_tx_valid));
                    check_field("tx_byte", due.tx_byte, i_tx_byte);
                    check_field("phase", 8'(due.phase), 8'(i_phase));
                    check_field("connected", 8'(due.connected), 8'(i_connected));
                    check_field("visitor_id", due.visitor, i_visitor_id);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OWN_ID:        own_id        = i_cfg_data[3:0];
                    CFG_MIN_ID:        min_id        = i_cfg_data[3:0];
                    CFG_MAX_ID:        max_id        = i_cfg_data[3:0];
                    CFG_BEACON_CODE:   beacon_code   = i_cfg_data[7:0];
                    CFG_IAM_CODE:      iam_code      = i_cfg_data[7:0];
                    CFG_ACK_CODE:      ack_code      = i_cfg_data[7:0];
                    CFG_BEACON_PERIOD: beacon_period = i_cfg_data[15:0];
                    CFG_REPLY_TIMEOUT: reply_timeout = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(advance_link(i_req_type, i_rx_byte));
            end
        end
        o_pending <= results_due.size();
    end

endmodule

### verif/beacon_identify_ack_handshake_core_tb.sv
// ----------------------------------------------------------------------------
// Handshake core testbench
// Drives ticks and received bytes into the core under several register
// settings: a directed part with the extremes and the corner cases, random
// handshake attempts, and a final handshake that completes. The checker does
// the rest.
// ----------------------------------------------------------------------------
module beacon_identify_ack_handshake_core_tb import biah_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_BYTE     = 1'b1;
    localparam int   CYCLE_LIMIT  = 40000;
    localparam int   PHASES       = 10;
    localparam int   PHASE_ITEMS  = 98;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  req_type  = REQ_TICK;
    logic [7:0]            rx_byte   = '0;
    logic                  out_ready = 1'b0;

    logic                  in_ready;
    logic                  out_valid;
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic [1:0]            phase;
    logic                  connected;
    logic [7:0]            visitor_id;

    int                    mismatches;
    int                    pending;
    bit                    idle_on     = 1'b0;
    int                    items_sent  = 0;
    int                    cycle_count = 0;
    int                    ready_hold  = 0;

    // Register values as last written, for building request bytes.
    logic [3:0]            own_id   = RST_OWN_ID;
    logic [3:0]            min_id   = RST_MIN_ID;
    logic [3:0]            max_id   = RST_MAX_ID;
    logic [7:0]            iam_code = RST_IAM_CODE;
    logic [7:0]            ack_code = RST_ACK_CODE;

    always #4 clk = ~clk;

    beacon_identify_ack_handshake_core uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_rx_byte    (rx_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_tx_valid   (tx_valid),
        .o_tx_byte    (tx_byte),
        .o_phase      (phase),
        .o_connected  (connected),
        .o_visitor_id (visitor_id)
    );

    beacon_identify_ack_handshake_checker watcher (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_req_type   (req_type),
        .i_rx_byte    (rx_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_tx_valid   (tx_valid),
        .i_tx_byte    (tx_byte),
        .i_phase      (phase),
        .i_connected  (connected),
        .i_visitor_id (visitor_id),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Result side: while idles are on, out_ready is now and then held low for a burst.
    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] iam_byte();
        return 8'(iam_code + 16 * own_id);
    endfunction

    function automatic logic [7:0] ack_byte();
        return 8'(ack_code + 16 * own_id);
    endfunction

    // A visitor byte that can never complete the handshake by accident.
    function automatic logic [7:0] pick_visitor();
        logic [7:0] v;
        if (min_id <= max_id && $urandom_range(0, 4) != 0) begin
            v = 8'($urandom_range(min_id, max_id));
        end else begin
            v = 8'($urandom);
        end
        if (v == ack_byte()) begin
            v = v ^ 8'h80;
        end
        return v;
    endfunction

    task automatic put_request(input logic kind, input logic [7:0] data);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        rx_byte  <= data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick();
        put_request(REQ_TICK, 8'($urandom));
    endtask

    task automatic send_stray_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == ack_byte()) b = 8'($urandom);
        put_request(REQ_BYTE, b);
    endtask

    task automatic wait_link_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_link(input logic [3:0] own, input logic [3:0] lo,
                                input logic [3:0] hi, input logic [7:0] bcode,
                                input logic [7:0] iam, input logic [7:0] ack,
                                input logic [15:0] period, input logic [15:0] timeout);
        logic [15:0] junk;
        wait_link_idle();
        // Now and then the unused upper bits of the narrow registers are set.
        junk = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0000;
        write_reg(CFG_OWN_ID, {junk[15:4], own});
        write_reg(CFG_MIN_ID, {junk[15:4], lo});
        write_reg(CFG_MAX_ID, {junk[15:4], hi});
        write_reg(CFG_BEACON_CODE, {junk[15:8], bcode});
        write_reg(CFG_IAM_CODE, {junk[15:8], iam});
        write_reg(CFG_ACK_CODE, {junk[15:8], ack});
        write_reg(CFG_BEACON_PERIOD, period);
        write_reg(CFG_REPLY_TIMEOUT, timeout);
        cfg_we   <= 1'b0;
        own_id   = own;
        min_id   = lo;
        max_id   = hi;
        iam_code = iam;
        ack_code = ack;
    endtask

    // Mostly handshake attempts with random content; the acknowledge that
    // would connect is never sent here, so every attempt ends in a failure.
    task automatic run_random_phase(input int quota);
        int stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7 && iam_byte() != ack_byte()) begin
                put_request(REQ_BYTE, iam_byte());
                repeat ($urandom_range(0, 2)) send_tick();
                put_request(REQ_BYTE, pick_visitor());
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 1) == 0) send_tick();
                    else send_stray_byte();
                end
            end else if ($urandom_range(0, 1) == 0) begin
                send_tick();
            end else begin
                send_stray_byte();
            end
        end
    endtask

    initial begin
        logic [3:0]  own, lo, hi, swap;
        logic [7:0]  bcode, iam, ack;
        logic [15:0] period, timeout;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // Reset settings: unmatched bytes, visitors out of range, discards.
        put_request(REQ_TICK, 8'hFF);
        put_request(REQ_BYTE, 8'h00);
        put_request(REQ_BYTE, 8'hFF);
        put_request(REQ_BYTE, ack_byte());
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, 8'hFF);
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, ack_byte());
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, 8'h0F);
        send_tick();
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, 8'h00);
        send_tick();

        // Zero beacon period and zero reply timeout.
        program_link(4'd0, 4'd0, 4'd0, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_tick();
        send_tick();
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, 8'h00);
        put_request(REQ_BYTE, iam_byte());
        send_tick();

        // Largest settings: widest codes and identifiers, longest period and timeout.
        program_link(4'd15, 4'd15, 4'd15, 8'h0F, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        put_request(REQ_BYTE, iam_byte());
        put_request(REQ_BYTE, 8'h0F);
        send_tick();
        put_request(REQ_BYTE, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            own     = 4'($urandom);
            lo      = 4'($urandom);
            hi      = 4'($urandom);
            bcode   = 8'($urandom);
            iam     = 8'($urandom);
            ack     = 8'($urandom);
            period  = 16'($urandom_range(1, 10));
            timeout = 16'($urandom_range(1, 12));
            if (lo > hi) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            case ($urandom_range(0, 9))
                0: period = 16'h0000;
                1: period = 16'hFFFF;
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: timeout = 16'h0000;
                1: timeout = 16'hFFFF;
                default: ;
            endcase
            if (p == 0) begin
                own = 4'd0; lo = 4'd0; hi = 4'd15;
                bcode = 8'h00; iam = 8'h00; ack = 8'hFF;
                period = 16'd1; timeout = 16'd1;
            end else if (p == 1) begin
                own = 4'd15; lo = 4'd0; hi = 4'd15;
                bcode = 8'hFF; iam = 8'hFF; ack = 8'h00;
                period = 16'd2; timeout = 16'd3;
            end else if (p == 2) begin
                // Empty visitor range: nobody is ever accepted.
                lo = 4'd12;
                hi = 4'd3;
            end
            while (ack == iam) ack = 8'($urandom);
            idle_on = (p % 4 != 3);
            program_link(own, lo, hi, bcode, iam, ack, period, timeout);
            run_random_phase(PHASE_ITEMS);
        end

        // Complete handshake, then requests that the connected core ignores.
        // The ticks first time out any reply still awaited from the last phase.
        idle_on = 1'b0;
        program_link(4'd6, 4'd2, 4'd9, 8'h40, 8'h33, 8'h5A, 16'd4, 16'd30);
        repeat (31) send_tick();
        put_request(REQ_BYTE, iam_byte());
        send_tick();
        put_request(REQ_BYTE, 8'h07);
        send_stray_byte();
        send_tick();
        put_request(REQ_BYTE, ack_byte());
        repeat (4) begin
            send_tick();
            put_request(REQ_BYTE, iam_byte());
        end

        wait_link_idle();
        repeat (3) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/biah_pkg.sv
sv/beacon_identify_ack_handshake_core.sv
verif/beacon_identify_ack_handshake_checker.sv
verif/beacon_identify_ack_handshake_core_tb.sv
